// ===== src/shift_insert_array_store_assert.svh =====
// Assertion macros for the shift insert array store.
// Needs nothing else; files that assert take it by include.
`ifndef SHIFT_INSERT_ARRAY_STORE_ASSERT_SVH
`define SHIFT_INSERT_ARRAY_STORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SIAS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define SIAS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SIAS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SIAS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/sias_pkg.sv =====
// Shared types of the shift insert array store: operation and status codes,
// and the enable group of the element memory port. No dependencies.
`default_nettype none
package sias_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_REMOVE = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_READ   = 3'd4,
    OP_WRITE  = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage
`default_nettype wire

// ===== src/sias_mem.sv =====
// Element memory: one write port, one read port, read data registered.
// Depends on sias_pkg for the port enable group.
`default_nettype none
module sias_mem
  import sias_pkg::*;
#(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire mem_ctl_t          ctl,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic signed [31:0] wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output logic signed [31:0]     rd_data
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/sias_ctrl.sv =====
// Sequencer of the shift insert array store: decodes items, walks the
// shift loop over the element memory and holds the result register.
// Depends on sias_pkg and shift_insert_array_store_assert.svh.
`default_nettype none
`include "shift_insert_array_store_assert.svh"
module sias_ctrl
  import sias_pkg::*;
#(
  parameter int CAPACITY = 256,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         op,
  input  wire logic [8:0]         position,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      read_value,
  output logic [8:0]              count,
  output logic                    is_empty,
  output logic [1:0]              status,
  output mem_ctl_t                mem_ctl,
  output logic [AW-1:0]           wr_addr,
  output logic signed [31:0]      wr_data,
  output logic [AW-1:0]           rd_addr,
  input  wire logic signed [31:0] rd_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > 9) ? CW : 9) + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_DRAIN = 6'b000100,
    S_TAIL  = 6'b001000,
    S_READ  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      cnt, cnt_next;
  status_t            stat_next, res_status;
  logic signed [31:0] res_value;
  logic [AW-1:0]      rd_ptr, rd_ptr_next, end_ptr, end_ptr_next;
  logic               ins, ins_next;
  logic               pend_valid;
  logic [AW-1:0]      pend_addr;
  logic [AW-1:0]      pos_q;
  logic signed [31:0] val_q;
  logic [XW-1:0]      pos_x, cnt_x;
  logic               full, pos_lt, pos_le, more_after, out_free;

  assign pos_x      = XW'(position);
  assign cnt_x      = XW'(cnt);
  assign full       = (cnt == CW'(CAPACITY));
  assign pos_lt     = (pos_x < cnt_x);
  assign pos_le     = (pos_x <= cnt_x);
  assign more_after = ((pos_x + XW'(1)) < cnt_x);
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE);

  always_comb begin
    state_next   = S_DONE;
    cnt_next     = cnt;
    stat_next    = ST_OK;
    rd_ptr_next  = rd_ptr;
    end_ptr_next = end_ptr;
    ins_next     = ins;
    mem_ctl      = '0;
    wr_addr      = pend_addr;
    wr_data      = rd_data;
    rd_addr      = rd_ptr;
    unique case (state)
      S_IDLE: begin
        wr_data = value;
        if (in_valid) begin
          case (op)
            OP_APPEND: begin
              if (full) begin
                stat_next = ST_FULL;
              end else begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = AW'(cnt);
                cnt_next      = cnt + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (cnt != '0) begin
                cnt_next = cnt - CW'(1);
              end
            end
            OP_INSERT: begin
              if (!pos_le) begin
                stat_next = ST_RANGE;
              end else if (full) begin
                stat_next = ST_FULL;
              end else begin
                cnt_next = cnt + CW'(1);
                if (pos_lt) begin
                  // open a hole: copy from the top down to position
                  state_next   = S_SHIFT;
                  rd_ptr_next  = AW'(cnt - CW'(1));
                  end_ptr_next = AW'(pos_x);
                  ins_next     = 1'b1;
                end else begin
                  mem_ctl.wr_en = 1'b1;
                  wr_addr       = AW'(pos_x);
                end
              end
            end
            OP_ERASE: begin
              if (!pos_lt) begin
                stat_next = ST_RANGE;
              end else begin
                cnt_next = cnt - CW'(1);
                if (more_after) begin
                  // close the gap: copy upward from position plus one
                  state_next   = S_SHIFT;
                  rd_ptr_next  = AW'(pos_x + XW'(1));
                  end_ptr_next = AW'(cnt - CW'(1));
                  ins_next     = 1'b0;
                end
              end
            end
            OP_READ: begin
              if (!pos_lt) begin
                stat_next = ST_RANGE;
              end else begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = AW'(pos_x);
                state_next    = S_READ;
              end
            end
            OP_WRITE: begin
              if (!pos_lt) begin
                stat_next = ST_RANGE;
              end else begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = AW'(pos_x);
              end
            end
            OP_CLEAR: cnt_next = '0;
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        mem_ctl.rd_en = 1'b1;
        mem_ctl.wr_en = pend_valid;
      end
      S_DRAIN: mem_ctl.wr_en = 1'b1;
      S_TAIL: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = pos_q;
        wr_data       = val_q;
      end
      S_READ, S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      pend_valid <= (state == S_SHIFT);
      // raise on a new result, drop once the receiver takes it
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state      <= state_next;
            cnt        <= cnt_next;
            res_status <= stat_next;
            res_value  <= '0;
            rd_ptr     <= rd_ptr_next;
            end_ptr    <= end_ptr_next;
            ins        <= ins_next;
            pos_q      <= AW'(pos_x);
            val_q      <= value;
          end
        end
        S_SHIFT: begin
          pend_addr <= ins ? rd_ptr + AW'(1) : rd_ptr - AW'(1);
          if (rd_ptr == end_ptr) begin
            state <= S_DRAIN;
          end else begin
            rd_ptr <= ins ? rd_ptr - AW'(1) : rd_ptr + AW'(1);
          end
        end
        S_DRAIN: state <= ins ? S_TAIL : S_DONE;
        S_TAIL:  state <= S_DONE;
        S_READ: begin
          res_value <= rd_data;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            read_value <= res_value;
            count      <= 9'(cnt);
            is_empty   <= (cnt == '0);
            status     <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SIAS_ASSERT_IMP(a_no_rw_clash, clk, rst, mem_ctl.wr_en && mem_ctl.rd_en, wr_addr != rd_addr)
  `SIAS_ASSERT_NXT(a_shift_writes_back, clk, rst, state == S_SHIFT, mem_ctl.wr_en)
  `SIAS_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= CW'(CAPACITY))
  `SIAS_ASSERT_NXT(a_done_waits, clk, rst, state == S_DONE && out_valid && !out_ready, state == S_DONE)

endmodule
`default_nettype wire

// ===== src/shift_insert_array_store.sv =====
// Shift insert array store: ordered array of signed words with a count.
// Result is registered out via S_DONE, after S_READ for a successful read; insert
// at p below n stored passes S_SHIFT, S_DRAIN and S_TAIL, erase with later elements
// S_SHIFT and S_DRAIN, the copy loop moving one element per cycle through memory.
// Next item is taken once the previous result sits in the output register.
// Synchronous reset clears the count and control; stored words stay undefined.
`default_nettype none
module shift_insert_array_store
  import sias_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         op,
  input  wire logic [8:0]         position,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      read_value,
  output logic [8:0]              count,
  output logic                    is_empty,
  output logic [1:0]              status
);

  // address width of the element memory
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] wr_data;
  logic signed [31:0] rd_data;

  // sequencer: decode, shift loop, result register
  sias_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .count      (count),
    .is_empty   (is_empty),
    .status     (status),
    .mem_ctl    (mem_ctl),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  // element memory: hold the stored words
  sias_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire
